/* rtl/longest_free_gap_finder_macros.svh */
// assertion macros for the longest free gap finder checker
// no dependencies; included by the checker file only
`ifndef LONGEST_FREE_GAP_FINDER_MACROS_SVH
`define LONGEST_FREE_GAP_FINDER_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define LFGF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfgf check failed");

// next-cycle implication, quiet while reset is asserted
`define LFGF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfgf check failed");

`endif

/* rtl/lfgf_pkg.sv */
// shared types and constants of the longest free gap finder
// no dependencies; imported by every module of the block but lfgf_ram
package lfgf_pkg;

    localparam int FIELD_W  = 11;  // width of every slot field
    localparam int WORD_W   = 64;  // slots per map word
    localparam int WORD_SH  = 6;   // log2 of WORD_W
    localparam int CHUNK_W  = 8;   // slots scanned per cycle
    localparam int CHUNK_SH = 3;   // log2 of CHUNK_W
    localparam int CSEL_W   = WORD_SH - CHUNK_SH;

    localparam logic [FIELD_W-1:0] WIN_START_RST = 11'd420;
    localparam logic [FIELD_W-1:0] WIN_END_RST   = 11'd1380;
    localparam logic [FIELD_W-1:0] MIN_GAP_RST   = 11'd2;

    typedef enum logic [1:0] {
        ACT_MARK  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2
    } lfgf_action_t;

    typedef enum logic [1:0] {
        REG_WIN_START = 2'd0,
        REG_WIN_END   = 2'd1,
        REG_MIN_GAP   = 2'd2
    } lfgf_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_QUERY_RD,
        ST_QUERY_SCAN,
        ST_QUERY_FIN
    } lfgf_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic start_mark;
        logic start_query;
        logic clear_map;
        logic mark_rd;
        logic mark_wr;
        logic query_rd;
        logic query_scan;
        logic load_result;
    } lfgf_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic mark_empty;
        logic window_empty;
        logic last_row;
        logic last_chunk;
        logic out_free;
    } lfgf_stat_t;

endpackage

/* rtl/lfgf_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module lfgf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lfgf_ctrl.sv */
// controller state machine of the longest free gap finder
// depends on lfgf_pkg; drives the datapath through lfgf_cmd_t
module lfgf_ctrl
    import lfgf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  lfgf_stat_t stat,
    output lfgf_cmd_t  cmd
);

    lfgf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (lfgf_action_t'(action))
                        ACT_MARK:
                        begin
                            cmd.start_mark = 1'b1;
                            if (!stat.mark_empty)
                            begin
                                state_next = ST_MARK_RD;
                            end
                        end
                        ACT_QUERY:
                        begin
                            cmd.start_query = 1'b1;
                            state_next = stat.window_empty ? ST_QUERY_FIN : ST_QUERY_RD;
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clear_map = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MARK_RD:
            begin
                cmd.mark_rd = 1'b1;
                state_next  = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                cmd.mark_wr = 1'b1;
                state_next  = stat.last_row ? ST_IDLE : ST_MARK_RD;
            end
            ST_QUERY_RD:
            begin
                cmd.query_rd = 1'b1;
                state_next   = ST_QUERY_SCAN;
            end
            ST_QUERY_SCAN:
            begin
                cmd.query_scan = 1'b1;
                if (stat.last_chunk && stat.last_row)
                begin
                    state_next = ST_QUERY_FIN;
                end
            end
            ST_QUERY_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/lfgf_datapath.sv */
// datapath: config registers, busy map words, scan registers, result register
// depends on lfgf_pkg and lfgf_ram; steered by lfgf_ctrl commands
module lfgf_datapath
    import lfgf_pkg::*;
#(
    parameter int SLOTS = 1440
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic [FIELD_W-1:0] range_start,
    input  logic [FIELD_W-1:0] range_end,
    input  lfgf_cmd_t          cmd,
    output lfgf_stat_t         stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [FIELD_W-1:0] gap_start,
    output logic [FIELD_W-1:0] gap_end,
    output logic [FIELD_W-1:0] gap_length
);

    localparam int NR = (SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW = (NR > 1) ? $clog2(NR) : 1;
    localparam int IW = $clog2(NR * WORD_W + 1);
    localparam int XW = IW + FIELD_W;

    typedef struct packed {
        logic [IW-1:0] run;
        logic [IW-1:0] best_len;
        logic [IW-1:0] best_start;
    } scan_t;

    function automatic logic [IW-1:0] clamp_slot(input logic [FIELD_W-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        if (w > XW'(SLOTS))
        begin
            w = XW'(SLOTS);
        end
        return w[IW-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [IW-1:0] v);
        logic [XW-1:0] w;
        w = XW'(v);
        return w[FIELD_W-1:0];
    endfunction

    // one chunk of slots, in slot order
    function automatic scan_t scan_chunk(
        input logic [CHUNK_W-1:0] bits,
        input logic [IW-1:0]      base,
        input logic [IW-1:0]      ws,
        input logic [IW-1:0]      we,
        input logic [IW-1:0]      need,
        input scan_t              s_in
    );
        scan_t         s;
        logic [IW-1:0] idx;
        s = s_in;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            idx = base | IW'(i);
            if (idx >= ws && idx < we)
            begin
                if (!bits[i])
                begin
                    s.run = s.run + 1'b1;
                end
                else
                begin
                    if (s.run >= need && s.run > s.best_len)
                    begin
                        s.best_len   = s.run;
                        s.best_start = idx - s.run;
                    end
                    s.run = '0;
                end
            end
        end
        return s;
    endfunction

    // configuration registers
    logic [FIELD_W-1:0] win_start_reg, win_end_reg, min_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= WIN_START_RST;
            win_end_reg   <= WIN_END_RST;
            min_gap_reg   <= MIN_GAP_RST;
        end
        else if (cfg_write)
        begin
            case (lfgf_reg_t'(cfg_index))
                REG_WIN_START: win_start_reg <= cfg_data;
                REG_WIN_END:   win_end_reg   <= cfg_data;
                REG_MIN_GAP:   min_gap_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    logic [IW-1:0] ws_c, we_c, need_c, rs_c, re_c;
    logic [XW-1:0] need_w;

    always_comb
    begin
        ws_c   = clamp_slot(win_start_reg);
        we_c   = clamp_slot(win_end_reg);
        rs_c   = clamp_slot(range_start);
        re_c   = clamp_slot(range_end);
        // a need past the map can never be met, so saturate it there
        need_w = XW'(min_gap_reg);
        if (need_w == '0)
        begin
            need_w = XW'(1);
        end
        if (need_w > XW'(SLOTS + 1))
        begin
            need_w = XW'(SLOTS + 1);
        end
        need_c = need_w[IW-1:0];
    end

    // walk registers
    logic [IW-1:0]     a_reg, b_reg;
    logic [AW-1:0]     row_reg, last_row_reg;
    logic [CSEL_W-1:0] chunk_reg;
    scan_t             scan_reg;
    logic [NR-1:0]     row_valid_reg;
    logic              rd_valid_reg;

    logic              advance;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data, word, mask, wr_data;
    logic [IW-1:0]     slot_idx;
    scan_t             scan_next;
    logic [IW-1:0]     m_first, m_last, q_last;

    assign advance = cmd.query_scan && (chunk_reg == '1) && (row_reg != last_row_reg);
    assign rd_en   = cmd.mark_rd || cmd.query_rd || advance;
    assign rd_addr = advance ? AW'(row_reg + 1'b1) : row_reg;
    assign wr_en   = cmd.mark_wr;
    // a row never written since the last clear reads as all free
    assign word    = rd_valid_reg ? rd_data : '0;
    assign m_first = rs_c >> WORD_SH;
    assign m_last  = (re_c - 1'b1) >> WORD_SH;
    assign q_last  = (we_c - 1'b1) >> WORD_SH;

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            slot_idx = IW'({row_reg, WORD_SH'(i)});
            mask[i]  = (slot_idx >= a_reg) && (slot_idx < b_reg);
        end
        wr_data   = word | mask;
        scan_next = scan_chunk(word[chunk_reg*CHUNK_W +: CHUNK_W],
                               IW'({row_reg, chunk_reg, CHUNK_SH'(0)}),
                               ws_c, we_c, need_c, scan_reg);
    end

    lfgf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NR)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (row_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (cmd.clear_map)
        begin
            row_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            row_valid_reg[row_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (cmd.start_mark)
        begin
            a_reg        <= rs_c;
            b_reg        <= re_c;
            row_reg      <= m_first[AW+WORD_SH-1-WORD_SH:0];
            last_row_reg <= m_last[AW-1:0];
        end
        else if (cmd.start_query)
        begin
            row_reg      <= AW'(ws_c >> WORD_SH);
            last_row_reg <= q_last[AW-1:0];
            chunk_reg    <= '0;
            scan_reg     <= '0;
        end
        else if (cmd.mark_wr)
        begin
            if (row_reg != last_row_reg)
            begin
                row_reg <= AW'(row_reg + 1'b1);
            end
        end
        else if (cmd.query_scan)
        begin
            scan_reg  <= scan_next;
            chunk_reg <= chunk_reg + 1'b1;
            if (advance)
            begin
                row_reg <= AW'(row_reg + 1'b1);
            end
        end
    end

    // result register
    logic               out_valid_reg;
    logic               found_reg;
    logic [FIELD_W-1:0] gap_start_reg, gap_end_reg, gap_length_reg;
    logic [IW-1:0]      fin_len, fin_start;

    always_comb
    begin
        fin_len   = scan_reg.best_len;
        fin_start = scan_reg.best_start;
        // a run that reaches the window end still counts
        if (scan_reg.run >= need_c && scan_reg.run > scan_reg.best_len)
        begin
            fin_len   = scan_reg.run;
            fin_start = we_c - scan_reg.run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            if (fin_len != '0)
            begin
                found_reg      <= 1'b1;
                gap_start_reg  <= to_field(fin_start);
                gap_end_reg    <= to_field(IW'(fin_start + fin_len));
                gap_length_reg <= to_field(fin_len);
            end
            else
            begin
                found_reg      <= 1'b0;
                gap_start_reg  <= '0;
                gap_end_reg    <= '0;
                gap_length_reg <= '0;
            end
        end
    end

    assign stat.mark_empty   = (rs_c >= re_c);
    assign stat.window_empty = (ws_c >= we_c);
    assign stat.last_row     = (row_reg == last_row_reg);
    assign stat.last_chunk   = (chunk_reg == '1);
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign gap_start  = gap_start_reg;
    assign gap_end    = gap_end_reg;
    assign gap_length = gap_length_reg;

endmodule

/* rtl/longest_free_gap_finder.sv */
// longest free gap finder over a map of slot busy bits
// top level: links lfgf_ctrl and lfgf_datapath, depends on lfgf_pkg
//
// usage
// - input channel (in_valid/in_ready) carries one word: action, range_start,
//   range_end. mark sets slots [range_start, range_end) busy, clamped to the
//   map; clear frees every slot; query searches the configured window
// - a query gives one result word on the output channel (out_valid/out_ready):
//   found, gap_start, gap_end, gap_length of the earliest longest free run of
//   at least min_gap slots; mark, clear and the unused action code give none
// - the map is kept as 64-slot words in a ram; a query reads one word and then
//   walks it 8 slots a cycle over the map words the window touches, 16 of
//   them for the reset window
// - a mark reads then writes each map word it touches; clear and an empty
//   mark are done in the accept cycle
// - one word is worked on at a time; in_ready is high only when idle
// - the result sits in an output register, so the next word is taken while
//   the receiver stalls; only a second query waits for the slot to drain
// - cfg_write/cfg_index/cfg_data set window_start, window_end and min_gap;
//   write them only while idle
// - reset (rst_n low, asynchronous) frees every slot at once through per-word
//   valid flags and loads window 420 to 1380 with min_gap 2; no clearing pass
module longest_free_gap_finder
    import lfgf_pkg::*;
#(
    parameter int SLOTS = 1440
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [FIELD_W-1:0] range_start,
    input  logic [FIELD_W-1:0] range_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [FIELD_W-1:0] gap_start,
    output logic [FIELD_W-1:0] gap_end,
    output logic [FIELD_W-1:0] gap_length
);

    // command and status between controller and datapath
    lfgf_cmd_t  cmd;
    lfgf_stat_t stat;

    // sequencing of mark and query walks
    lfgf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    // map storage, scan arithmetic and result register
    lfgf_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .range_start (range_start),
        .range_end   (range_end),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .gap_start   (gap_start),
        .gap_end     (gap_end),
        .gap_length  (gap_length)
    );

endmodule

/* rtl/lfgf_checker.sv */
// port-level checks of the longest free gap finder, bound to the top level
// depends on lfgf_pkg and longest_free_gap_finder_macros.svh
`include "longest_free_gap_finder_macros.svh"

module lfgf_checker
    import lfgf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         action,
    input logic               out_valid,
    input logic               out_ready,
    input logic               found,
    input logic [FIELD_W-1:0] gap_start,
    input logic [FIELD_W-1:0] gap_end,
    input logic [FIELD_W-1:0] gap_length
);

    // a stalled result word keeps its fields
    `LFGF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(gap_start) && $stable(gap_end) && $stable(gap_length))

    // no gap means every field reads zero
    `LFGF_ASSERT_NOW(a_none_zero, clk, rst_n, out_valid && !found, gap_start == '0 && gap_end == '0 && gap_length == '0)

    // a reported gap is non-empty and its end is start plus length
    `LFGF_ASSERT_NOW(a_gap_span, clk, rst_n, out_valid && found, gap_length != '0 && gap_end == FIELD_W'(gap_start + gap_length))

    // an accepted query always makes the block busy, so in_ready drops
    `LFGF_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && in_ready && action == ACT_QUERY, !in_ready)

endmodule

bind longest_free_gap_finder lfgf_checker u_lfgf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .found      (found),
    .gap_start  (gap_start),
    .gap_end    (gap_end),
    .gap_length (gap_length)
);

/* tb/longest_free_gap_finder_tb.sv */
// testbench for longest_free_gap_finder: directed and random mark, clear and query words
// keeps its own slot map and window settings to predict every gap result; needs lfgf_pkg
// and the rtl of the block, nothing else
`timescale 1ns / 1ps

module longest_free_gap_finder_tb;
    import lfgf_pkg::*;

    localparam int SLOTS = 1440;
    // action code with no meaning: the block must drop the word
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // widest mark touches 23 map words, read then write each
    localparam int MARK_SETTLE_CYCLES = 64;
    // long enough for a query over the whole map of 23 words
    localparam int QUERY_SETTLE_CYCLES = 200;
    localparam int TIMEOUT_NS = 1500000;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] gap_start;
        logic [FIELD_W-1:0] gap_end;
        logic [FIELD_W-1:0] gap_length;
    } gap_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [FIELD_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         action;
    logic [FIELD_W-1:0] range_start;
    logic [FIELD_W-1:0] range_end;
    logic               out_valid;
    logic               out_ready;
    logic               found;
    logic [FIELD_W-1:0] gap_start;
    logic [FIELD_W-1:0] gap_end;
    logic [FIELD_W-1:0] gap_length;

    // predictor state: own copy of the busy map and the window registers
    bit                 slot_busy [SLOTS];
    logic [FIELD_W-1:0] win_start;
    logic [FIELD_W-1:0] win_end;
    logic [FIELD_W-1:0] min_gap;

    // gap results still owed by the block, oldest first
    gap_result_t pending_gaps [$];
    gap_result_t seen_gap;
    gap_result_t want_gap;

    int errors;
    int words_sent;
    int queries_sent;
    int results_checked;
    int settings_used;

    // idling knobs, percent of cycles
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off, handed to the receiver process
    int hold_request;
    int hold_left;

    longest_free_gap_finder #(
        .SLOTS(SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .range_start(range_start),
        .range_end  (range_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .gap_start  (gap_start),
        .gap_end    (gap_end),
        .gap_length (gap_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic int clamp_slot(input int v);
        return (v > SLOTS) ? SLOTS : v;
    endfunction

    // earliest longest free run in the window, at least min_gap long
    function automatic gap_result_t longest_gap();
        int          ws;
        int          we;
        int          need;
        int          run;
        int          best_len;
        int          best_start;
        gap_result_t r;
        ws = clamp_slot(win_start);
        we = clamp_slot(win_end);
        need = (min_gap == '0) ? 1 : int'(min_gap);
        run = 0;
        best_len = 0;
        best_start = 0;
        for (int i = ws; i < we; i++)
        begin
            if (!slot_busy[i])
                run++;
            else
            begin
                // strictly longer only, so ties keep the earliest run
                if (run >= need && run > best_len)
                begin
                    best_len = run;
                    best_start = i - run;
                end
                run = 0;
            end
        end
        // a run still open at the window end counts too
        if (ws < we && run >= need && run > best_len)
        begin
            best_len = run;
            best_start = we - run;
        end
        r = '0;
        if (best_len > 0)
        begin
            r.found = 1'b1;
            r.gap_start = FIELD_W'(best_start);
            r.gap_end = FIELD_W'(best_start + best_len);
            r.gap_length = FIELD_W'(best_len);
        end
        return r;
    endfunction

    // update the map for an accepted word, queue a result for a query
    function automatic void apply_word(input logic [1:0] act,
                                       input logic [FIELD_W-1:0] rs,
                                       input logic [FIELD_W-1:0] re);
        int lo;
        int hi;
        lo = clamp_slot(rs);
        hi = clamp_slot(re);
        case (act)
            ACT_MARK:
                for (int i = lo; i < hi; i++)
                    slot_busy[i] = 1'b1;
            ACT_QUERY:
            begin
                pending_gaps.push_back(longest_gap());
                queries_sent++;
            end
            ACT_CLEAR:
                slot_busy = '{default: 1'b0};
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // offer one word and wait for the handshake; valid is left high so a
    // back-to-back word follows without a dip
    task automatic send_word(input logic [1:0] act,
                             input logic [FIELD_W-1:0] rs,
                             input logic [FIELD_W-1:0] re);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        action <= act;
        range_start <= rs;
        range_end <= re;
        do
            @(posedge clk);
        while (!in_ready);
        apply_word(act, rs, re);
        words_sent++;
    endtask

    // stop offering, wait for every owed result, then let a trailing mark finish
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (pending_gaps.size() != 0)
            @(posedge clk);
        repeat (MARK_SETTLE_CYCLES) @(posedge clk);
    endtask

    // all three registers, back to back; only called with the block idle
    task automatic set_window(input logic [FIELD_W-1:0] ws,
                              input logic [FIELD_W-1:0] we,
                              input logic [FIELD_W-1:0] mg);
        cfg_write <= 1'b1;
        cfg_index <= REG_WIN_START;
        cfg_data <= ws;
        @(posedge clk);
        cfg_index <= REG_WIN_END;
        cfg_data <= we;
        @(posedge clk);
        cfg_index <= REG_MIN_GAP;
        cfg_data <= mg;
        @(posedge clk);
        cfg_write <= 1'b0;
        win_start = ws;
        win_end = we;
        min_gap = mg;
        settings_used++;
    endtask

    // receiver: random stalls, or a long hold-off counted here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // result check: every accepted result against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_gap = '{found, gap_start, gap_end, gap_length};
            if (pending_gaps.size() == 0)
            begin
                errors++;
                $display("%0t: result with none owed: found=%0b start=%0d end=%0d length=%0d",
                         $time, seen_gap.found, seen_gap.gap_start, seen_gap.gap_end,
                         seen_gap.gap_length);
            end
            else
            begin
                want_gap = pending_gaps.pop_front();
                results_checked++;
                if (seen_gap.found !== want_gap.found
                    || seen_gap.gap_start !== want_gap.gap_start
                    || seen_gap.gap_end !== want_gap.gap_end
                    || seen_gap.gap_length !== want_gap.gap_length)
                begin
                    errors++;
                    $display("%0t: gap mismatch: expected found=%0b start=%0d end=%0d len=%0d",
                             $time, want_gap.found, want_gap.gap_start, want_gap.gap_end,
                             want_gap.gap_length);
                    $display("%0t:               actual found=%0b start=%0d end=%0d len=%0d",
                             $time, seen_gap.found, seen_gap.gap_start, seen_gap.gap_end,
                             seen_gap.gap_length);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // empty map with the reset window: one gap over the whole window
    task automatic test_reset_defaults();
        send_word(ACT_QUERY, 11'd0, 11'd0);
    endtask

    // mark corner cases under the reset window
    task automatic test_mark_cases();
        send_word(ACT_MARK, 11'd0, 11'd0);          // empty range
        send_word(ACT_MARK, 11'd700, 11'd650);      // reversed range
        send_word(ACT_MARK, 11'd2047, 11'd2047);    // both past the map
        send_word(ACT_QUERY, 11'd2047, 11'd2047);
        send_word(ACT_MARK, 11'd600, 11'd605);
        send_word(ACT_MARK, 11'd1430, 11'd2047);    // end clamped to the map
        send_word(ACT_MARK, 11'd419, 11'd421);      // straddles window start
        send_word(ACT_QUERY, 11'd0, 11'd0);
        // unused code with a range that would fill the map if taken as a mark
        send_word(ACT_UNUSED, 11'd0, 11'd2047);
        send_word(ACT_QUERY, 11'd0, 11'd0);
        send_word(ACT_CLEAR, 11'd2047, 11'd0);
        send_word(ACT_QUERY, 11'd0, 11'd0);
    endtask

    // window and minimum gap settings, the extremes among them
    task automatic test_window_cases();
        // whole map, minimum of zero, window end past the map
        drain_and_settle();
        set_window(11'd0, 11'd2047, 11'd0);
        send_word(ACT_MARK, 11'd0, 11'd1);
        send_word(ACT_MARK, 11'd1439, 11'd2047);
        send_word(ACT_QUERY, 11'd0, 11'd0);
        send_word(ACT_MARK, 11'd0, 11'd2047);       // every slot busy: nothing found
        send_word(ACT_QUERY, 11'd0, 11'd0);
        send_word(ACT_CLEAR, 11'd0, 11'd0);

        // equal longest runs: earliest wins; then a minimum no run reaches
        drain_and_settle();
        set_window(11'd490, 11'd540, 11'd5);
        send_word(ACT_MARK, 11'd500, 11'd510);
        send_word(ACT_MARK, 11'd520, 11'd530);
        send_word(ACT_QUERY, 11'd0, 11'd0);
        drain_and_settle();
        set_window(11'd490, 11'd540, 11'd11);
        send_word(ACT_QUERY, 11'd0, 11'd0);

        // longest run open at the window end
        drain_and_settle();
        set_window(11'd100, 11'd200, 11'd2);
        send_word(ACT_MARK, 11'd150, 11'd160);
        send_word(ACT_MARK, 11'd100, 11'd145);
        send_word(ACT_QUERY, 11'd0, 11'd0);

        // reversed, empty and fully clamped windows
        drain_and_settle();
        set_window(11'd900, 11'd100, 11'd1);
        send_word(ACT_QUERY, 11'd0, 11'd0);
        drain_and_settle();
        set_window(11'd2047, 11'd2047, 11'd1);
        send_word(ACT_QUERY, 11'd0, 11'd0);

        // minimum gap longer than the map
        drain_and_settle();
        set_window(11'd0, 11'd1440, 11'd2047);
        send_word(ACT_CLEAR, 11'd0, 11'd0);
        send_word(ACT_QUERY, 11'd0, 11'd0);
    endtask

    // receiver held off for a long stretch while words keep coming, so the
    // output register fills and the block stops taking words; then the
    // sender waits until every result is in
    task automatic test_output_stall();
        drain_and_settle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_window(11'd0, 11'd1440, 11'd1);
        hold_request = 400;
        repeat (8)
        begin
            send_word(ACT_QUERY, 11'($urandom), 11'($urandom));
            send_word(ACT_MARK, 11'($urandom_range(SLOTS - 1)), 11'($urandom_range(SLOTS)));
        end
        drain_and_settle();
    endtask

    // one setting per phase, mostly a sensible window, now and then raw bits
    task automatic pick_random_window();
        logic [FIELD_W-1:0] ws;
        logic [FIELD_W-1:0] we;
        logic [FIELD_W-1:0] mg;
        ws = 11'($urandom_range(700));
        we = 11'(ws + $urandom_range(900));
        mg = 11'($urandom_range(12));
        if ($urandom_range(7) == 0)
            ws = 11'($urandom);
        if ($urandom_range(7) == 0)
            we = 11'($urandom);
        if ($urandom_range(7) == 0)
            mg = 11'($urandom);
        set_window(ws, we, mg);
    endtask

    // mostly short marks and queries with clears now and then, so the map
    // keeps a mix of free and busy runs; the rest is raw noise
    task automatic test_random_traffic(input int words, input int idle_pct,
                                       input int stall_pct);
        int                 pick;
        logic [FIELD_W-1:0] s;
        logic [FIELD_W-1:0] e;
        drain_and_settle();
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        pick_random_window();
        repeat (words)
        begin
            pick = $urandom_range(99);
            s = 11'($urandom);
            e = 11'($urandom);
            if (pick < 50)
            begin
                if ($urandom_range(9) != 0)
                begin
                    s = 11'($urandom_range(SLOTS - 1));
                    e = 11'(s + $urandom_range(1, 60));
                end
                send_word(ACT_MARK, s, e);
            end
            else if (pick < 85)
                send_word(ACT_QUERY, s, e);
            else if (pick < 92)
                send_word(ACT_CLEAR, s, e);
            else if (pick < 96)
                send_word(ACT_UNUSED, s, e);
            else
                send_word(ACT_MARK, s, e);
        end
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_WIN_START;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_MARK;
        range_start = '0;
        range_end = '0;
        out_ready = 1'b0;
        errors = 0;
        words_sent = 0;
        queries_sent = 0;
        results_checked = 0;
        settings_used = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        // reset values of the block
        slot_busy = '{default: 1'b0};
        win_start = WIN_START_RST;
        win_end = WIN_END_RST;
        min_gap = MIN_GAP_RST;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_mark_cases();
        test_window_cases();
        test_output_stall();
        test_random_traffic(100, 0, 0);
        test_random_traffic(100, 54, 0);
        test_random_traffic(100, 0, 54);
        test_random_traffic(100, 8, 8);

        drain_and_settle();
        repeat (QUERY_SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d words (%0d queries) over %0d window settings",
                 words_sent, queries_sent, settings_used);
        $display("%0d gap results checked, %0d mismatches", results_checked, errors);
        if (errors == 0 && pending_gaps.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #(TIMEOUT_NS);
        $display("watchdog expired with %0d results outstanding", pending_gaps.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
